// ===== rtl/core/mrr_pkg.sv =====
// Shared types, constants and helper functions for the multi-reader overwrite ring.
// Used by mrr_front, mrr_back and multi_reader_overwrite_ring_core.
// Depends on nothing else.
package mrr_pkg;

	localparam int RING_DEPTH  = 16;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int MAX_READERS = 8;
	localparam int RDR_AW      = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
	localparam int MSG_WIDTH   = 32;
	localparam int CNT_W       = 32;
	localparam int QLOG_W      = 3;

	localparam logic [QLOG_W-1:0] QLOG_RESET = 3'd4;

	localparam logic [1:0] FN_PUSH  = 2'd0;
	localparam logic [1:0] FN_SUB   = 2'd1;
	localparam logic [1:0] FN_GET   = 2'd2;
	localparam logic [1:0] FN_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NO_SLOT  = 2'd2;
	localparam logic [1:0] ST_INACTIVE = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  reader_id;
		logic [31:0] message_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] message_out;
		logic [3:0]  reader_count;
		logic [2:0]  assigned_id;
	} out_item_t;

	// Decoded command handed from the front end to the back end.
	typedef struct packed {
		logic                 is_push;
		logic                 is_sub;
		logic                 is_get;
		logic                 is_clr;
		logic                 rid_ok;
		logic [RDR_AW-1:0]    slot;
		logic [MSG_WIDTH-1:0] msg;
	} cmd_t;

	// Ring entries in use; an oversized setting is clamped to the ring depth.
	function automatic logic [RING_AW:0] qsize_f(input logic [QLOG_W-1:0] qlog);
		logic [QLOG_W-1:0] e;
		e = (qlog > QLOG_W'(RING_AW)) ? QLOG_W'(RING_AW) : qlog;
		return {{RING_AW{1'b0}}, 1'b1} << e;
	endfunction

endpackage

// ===== rtl/core/multi_reader_overwrite_ring_core.sv =====
// Top level of the multi-reader overwrite ring: queue size register, front end
// and back end. Depends on mrr_pkg, mrr_front and mrr_back.
//
// Usage:
// - Input channel: drive in_data and push; a transaction completes at a rising
//   edge with push high and full low. Operations are push, subscribe, get and
//   clear all readers.
// - Result channel: while empty is low the oldest result sits on out_data; a
//   transaction completes at a rising edge with pop high and empty low. Every
//   operation yields exactly one result, in order.
// - Configuration: cfg_wdata is written to the queue size register (log2 of
//   the ring entries in use) at an edge with cfg_we high. Write it only while
//   no operation is in flight.
// - Order: an accepted operation waits in the command queue, executes when the
//   result queue has room, and its registered result then sits on out_data.
// - Throughput: one operation per cycle unless stalled, set by the single
//   execution stage, reading one ring entry and one reader count per cycle.
// - Stalls: when pop stays low, the two-entry result queue fills, execution
//   stops and the command queue then fills and raises full.
// - Reset: all readers inactive, write count zero, queue size 16, both queues
//   empty. Ring contents are not cleared.
module multi_reader_overwrite_ring_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mrr_pkg::in_item_t          in_data,
	output logic                       full,
	output logic                       empty,
	input  logic                       pop,
	output mrr_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [mrr_pkg::QLOG_W-1:0] cfg_wdata
);
	import mrr_pkg::*;

	logic [QLOG_W-1:0] qlog_q;
	logic              cmd_valid;
	logic              cmd_take;
	cmd_t              cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlog_q <= QLOG_RESET;
		end else if (cfg_we) begin
			qlog_q <= cfg_wdata;
		end
	end

	mrr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_data   (in_data),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	mrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.qlog      (qlog_q),
		.pop       (pop),
		.empty     (empty),
		.out_data  (out_data)
	);

	// A refused subscribe can only happen with every reader slot taken.
	a_no_slot_all_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.status == ST_NO_SLOT) |-> (out_data.reader_count == 4'(MAX_READERS)))
		else $error("no-slot result with a free reader slot");

	// Only a successful get carries a message word.
	a_msg_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.status != ST_OK) |-> (out_data.message_out == '0))
		else $error("message word on a failed operation");

	// A granted slot implies a successful operation and at least one reader.
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.assigned_id != '0) |->
		(out_data.status == ST_OK && out_data.reader_count != '0))
		else $error("slot granted on a failed operation");

	// The oldest result holds while nothing leaves the result queue and the command queue is full.
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !empty && !pop) |=> $stable(out_data))
		else $error("result changed while stalled");

endmodule

// ===== rtl/core/mrr_front.sv =====
// Front end of the overwrite ring: accepts operations, decodes them and holds
// them in a two-entry command queue for the back end.
// Depends on mrr_pkg.
module mrr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mrr_pkg::in_item_t in_data,
	output logic             full,
	output logic             cmd_valid,
	output mrr_pkg::cmd_t    cmd,
	input  logic             cmd_take
);
	import mrr_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       accept;
	logic       take;

	assign full      = (cnt_q == 2'd2);
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign take      = cmd_take && cmd_valid;
	assign cmd       = ent_q[rd_q];

	always_comb begin
		dec.is_push = (in_data.func == FN_PUSH);
		dec.is_sub  = (in_data.func == FN_SUB);
		dec.is_get  = (in_data.func == FN_GET);
		dec.is_clr  = (in_data.func == FN_CLEAR);
		dec.rid_ok  = (32'(in_data.reader_id) < MAX_READERS);
		dec.slot    = in_data.reader_id[RDR_AW-1:0];
		dec.msg     = in_data.message_in[MSG_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wr_q <= !wr_q;
			end
			if (take) begin
				rd_q <= !rd_q;
			end
			case ({accept, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/mrr_back.sv =====
// Back end of the overwrite ring: ring storage, write count, reader state,
// execution of one command per cycle while the result queue has room, and
// a two-entry result queue. Depends on mrr_pkg.
module mrr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  mrr_pkg::cmd_t              cmd,
	output logic                       cmd_take,
	input  logic [mrr_pkg::QLOG_W-1:0] qlog,
	input  logic                       pop,
	output logic                       empty,
	output mrr_pkg::out_item_t         out_data
);
	import mrr_pkg::*;

	logic [MSG_WIDTH-1:0]   ring_q [RING_DEPTH];
	logic [CNT_W-1:0]       wc_q;
	logic [CNT_W-1:0]       rcnt_q [MAX_READERS];
	logic [MAX_READERS-1:0] active_q;

	out_item_t  res_q [2];
	logic       res_wr_q;
	logic       res_rd_q;
	logic [1:0] res_cnt_q;

	logic                   exec;
	logic                   res_pop;
	logic [RING_AW:0]       qsize;
	logic [RING_AW-1:0]     mask;
	logic [CNT_W-1:0]       rc;
	logic [CNT_W-1:0]       diff;
	logic [CNT_W-1:0]       rc_adj;
	logic [RING_AW-1:0]     rd_idx;
	logic [RING_AW-1:0]     wr_idx;
	logic                   found;
	logic [RDR_AW-1:0]      free_idx;
	logic                   get_ok;
	logic [MAX_READERS-1:0] act_nx;
	logic [3:0]             act_cnt;
	out_item_t              res;

	assign exec     = cmd_valid && (res_cnt_q != 2'd2);
	assign cmd_take = exec;
	assign empty    = (res_cnt_q == 2'd0);
	assign res_pop  = pop && !empty;
	assign out_data = res_q[res_rd_q];

	assign qsize  = qsize_f(qlog);
	assign mask   = RING_AW'(qsize - 1'b1);
	assign rc     = rcnt_q[cmd.slot];
	assign diff   = wc_q - rc;
	// A reader that fell behind by more than the queue size restarts at the oldest entry.
	assign rc_adj = (diff > CNT_W'(qsize)) ? (wc_q - CNT_W'(qsize)) : rc;
	assign rd_idx = rc_adj[RING_AW-1:0] & mask;
	assign wr_idx = wc_q[RING_AW-1:0] & mask;

	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = MAX_READERS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				found    = 1'b1;
				free_idx = RDR_AW'(i);
			end
		end
	end

	always_comb begin
		res.status       = ST_OK;
		res.message_out  = '0;
		res.reader_count = '0;
		res.assigned_id  = '0;
		act_nx           = active_q;
		get_ok           = 1'b0;
		if (cmd.is_sub) begin
			if (found) begin
				act_nx[free_idx] = 1'b1;
				res.assigned_id  = 3'(free_idx);
			end else begin
				res.status = ST_NO_SLOT;
			end
		end else if (cmd.is_get) begin
			if (!cmd.rid_ok || !active_q[cmd.slot]) begin
				res.status = ST_INACTIVE;
			end else if (rc == wc_q) begin
				res.status = ST_EMPTY;
			end else begin
				get_ok          = 1'b1;
				res.message_out = 32'(ring_q[rd_idx]);
			end
		end else if (cmd.is_clr) begin
			act_nx = '0;
		end
		act_cnt = '0;
		for (int i = 0; i < MAX_READERS; i++) begin
			act_cnt = act_cnt + 4'(act_nx[i]);
		end
		res.reader_count = act_cnt;
	end

	always_ff @(posedge clk) begin
		if (exec && cmd.is_push) begin
			ring_q[wr_idx] <= cmd.msg;
		end
		if (exec) begin
			res_q[res_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q     <= '0;
			active_q <= '0;
			for (int i = 0; i < MAX_READERS; i++) begin
				rcnt_q[i] <= '0;
			end
		end else if (exec) begin
			active_q <= act_nx;
			if (cmd.is_push) begin
				wc_q <= wc_q + 1'b1;
			end
			if (cmd.is_sub && found) begin
				rcnt_q[free_idx] <= wc_q;
			end
			if (get_ok) begin
				rcnt_q[cmd.slot] <= rc_adj + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (exec) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= !res_rd_q;
			end
			case ({exec, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for multi_reader_overwrite_ring_core: drives push, subscribe, get and clear
// transactions and checks each result against a predictor kept inside this file.
// Depends on mrr_pkg and the RTL of the core.
module tb;
	import mrr_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              push;
	in_item_t          in_data;
	logic              full;
	logic              empty;
	logic              pop;
	out_item_t         out_data;
	logic              cfg_we;
	logic [QLOG_W-1:0] cfg_wdata;

	multi_reader_overwrite_ring_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_data   (in_data),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state.
	logic [MSG_WIDTH-1:0]   ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0]  ring_seen;
	logic [CNT_W-1:0]       wr_count;
	logic [CNT_W-1:0]       rd_count [MAX_READERS];
	logic [MAX_READERS-1:0] rd_live;
	logic [QLOG_W-1:0]      qlog_now;

	out_item_t awaited_results [$];
	int        mismatches;
	bit        calm;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [CNT_W-1:0] ring_span();
		logic [CNT_W-1:0] s;
		s = 32'd1 << qlog_now;
		if (s > RING_DEPTH)
			s = RING_DEPTH;
		return s;
	endfunction

	// Position a get on this slot would read, after catching up a lagging reader.
	function automatic logic [CNT_W-1:0] catch_up(logic [2:0] rid);
		logic [CNT_W-1:0] rc;
		rc = rd_count[rid];
		if (wr_count - rc > ring_span())
			rc = wr_count - ring_span();
		return rc;
	endfunction

	function automatic bit get_reads_blank(logic [2:0] rid);
		logic [CNT_W-1:0] rc;
		if (!rd_live[rid] || rd_count[rid] == wr_count)
			return 1'b0;
		rc = catch_up(rid);
		return !ring_seen[RING_AW'(rc & (ring_span() - 1))];
	endfunction

	function automatic out_item_t ring_apply(in_item_t it);
		out_item_t        r;
		logic [CNT_W-1:0] rc;
		logic [RING_AW-1:0] idx;
		bit               found;
		r = '0;
		r.status = ST_OK;
		case (it.func)
			FN_PUSH: begin
				idx = RING_AW'(wr_count & (ring_span() - 1));
				ring_mem[idx] = it.message_in;
				ring_seen[idx] = 1'b1;
				wr_count = wr_count + 1;
			end
			FN_SUB: begin
				found = 1'b0;
				for (int i = 0; i < MAX_READERS; i++) begin
					if (!found && !rd_live[i]) begin
						found = 1'b1;
						rd_live[i] = 1'b1;
						rd_count[i] = wr_count;
						r.assigned_id = 3'(i);
					end
				end
				if (!found)
					r.status = ST_NO_SLOT;
			end
			FN_GET: begin
				if (!rd_live[it.reader_id]) begin
					r.status = ST_INACTIVE;
				end else if (rd_count[it.reader_id] == wr_count) begin
					r.status = ST_EMPTY;
				end else begin
					rc = catch_up(it.reader_id);
					r.message_out = ring_mem[RING_AW'(rc & (ring_span() - 1))];
					rd_count[it.reader_id] = rc + 1;
				end
			end
			default: rd_live = '0;
		endcase
		r.reader_count = 4'($countones(rd_live));
		return r;
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_op(in_item_t it);
		int n;
		n = idle_len();
		if (n > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		// A get must never land on a ring entry that was never written.
		if (it.func == FN_GET && get_reads_blank(it.reader_id))
			it.func = FN_PUSH;
		@(negedge clk);
		push <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		awaited_results.push_back(ring_apply(it));
	endtask

	task automatic op(logic [1:0] func, logic [2:0] rid, logic [31:0] msg);
		in_item_t it;
		it.func = func;
		it.reader_id = rid;
		it.message_in = msg;
		send_op(it);
	endtask

	task automatic settle();
		@(negedge clk) push <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_qlog(logic [QLOG_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk) cfg_we <= 1'b0;
		qlog_now = v;
	endtask

	function automatic in_item_t pick_op();
		in_item_t it;
		int       r;
		r = $urandom_range(0, 99);
		it.reader_id = 3'($urandom_range(0, 7));
		it.message_in = $urandom();
		if (rd_live == '0 && r < 60)
			it.func = FN_SUB;
		else if (r < 44)
			it.func = FN_PUSH;
		else if (r < 88)
			it.func = FN_GET;
		else if (r < 97)
			it.func = FN_SUB;
		else
			it.func = FN_CLEAR;
		// Most gets go to a live reader so that the read path is exercised.
		if (it.func == FN_GET && rd_live != '0 && $urandom_range(0, 9) < 9) begin
			while (!rd_live[it.reader_id])
				it.reader_id = 3'($urandom_range(0, 7));
		end
		return it;
	endfunction

	task automatic test_fresh_ring();
		op(FN_GET, 3'd0, 32'h1234_5678);
		op(FN_PUSH, 3'd7, 32'h0000_0000);
		op(FN_SUB, 3'd5, 32'hFFFF_FFFF);
		op(FN_GET, 3'd0, 32'h0);
		op(FN_PUSH, 3'd0, 32'hFFFF_FFFF);
		op(FN_GET, 3'd0, 32'h0);
		repeat (7) op(FN_SUB, 3'd0, 32'h0);
		op(FN_SUB, 3'd0, 32'h0);
		op(FN_PUSH, 3'd2, 32'h8000_0001);
		op(FN_GET, 3'd7, 32'h0);
		op(FN_GET, 3'd3, 32'h0);
		op(FN_CLEAR, 3'd6, 32'hA5A5_A5A5);
		op(FN_GET, 3'd7, 32'h0);
		op(FN_PUSH, 3'd1, 32'h5A5A_5A5A);
	endtask

	task automatic test_lagging_reader();
		// A two-entry ring lets a reader fall behind after a few pushes.
		set_qlog(3'd1);
		op(FN_SUB, 3'd0, 32'h0);
		for (int i = 0; i < 5; i++)
			op(FN_PUSH, 3'd0, 32'hC0DE_0000 + i);
		op(FN_GET, 3'd0, 32'h0);
		op(FN_GET, 3'd0, 32'h0);
		op(FN_GET, 3'd0, 32'h0);
		op(FN_PUSH, 3'd0, 32'hBEEF_0001);
		// The mask changes under a waiting reader; nothing moves in the ring.
		set_qlog(3'd7);
		op(FN_PUSH, 3'd0, 32'hBEEF_0002);
		op(FN_GET, 3'd0, 32'h0);
		op(FN_GET, 3'd0, 32'h0);
		set_qlog(3'd0);
		op(FN_PUSH, 3'd0, 32'hBEEF_0003);
		op(FN_PUSH, 3'd0, 32'hBEEF_0004);
		op(FN_GET, 3'd0, 32'h0);
	endtask

	task automatic test_random_traffic();
		logic [QLOG_W-1:0] sizes [9];
		sizes = '{3'd0, 3'd7, 3'd4, 3'd1, 3'd5, 3'd2, 3'd3, 3'd6, 3'd4};
		for (int p = 0; p < 9; p++) begin
			set_qlog(sizes[p]);
			calm = (p == 2);
			for (int i = 0; i < 150; i++) begin
				// Hold the sender once until every pending transaction is back.
				if (p == 5 && i == 75)
					settle();
				send_op(pick_op());
			end
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("result with no pending transaction", out_data.message_out, 32'h0);
			end else begin
				want = awaited_results.pop_front();
				if (out_data.status !== want.status)
					flag_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.message_out !== want.message_out)
					flag_mismatch("message_out", out_data.message_out, want.message_out);
				if (out_data.reader_count !== want.reader_count)
					flag_mismatch("reader_count", 32'(out_data.reader_count),
						32'(want.reader_count));
				if (out_data.assigned_id !== want.assigned_id)
					flag_mismatch("assigned_id", 32'(out_data.assigned_id),
						32'(want.assigned_id));
			end
		end
	end

	initial begin : drive_pop
		int n;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = idle_len();
			if (n > 0) begin
				@(negedge clk) pop <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk) pop <= 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("** multi_reader_overwrite_ring_core: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = QLOG_RESET;
		mismatches = 0;
		calm = 1'b0;
		ring_seen = '0;
		wr_count = '0;
		rd_live = '0;
		qlog_now = QLOG_RESET;
		for (int i = 0; i < MAX_READERS; i++)
			rd_count[i] = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_fresh_ring();
		test_lagging_reader();
		test_random_traffic();

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("** multi_reader_overwrite_ring_core: PASSED **");
		else
			$display("** multi_reader_overwrite_ring_core: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mrr_pkg.sv
rtl/core/mrr_front.sv
rtl/core/mrr_back.sv
rtl/core/multi_reader_overwrite_ring_core.sv
tb/sv/tb.sv
